[hdl/cosfl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cosfl_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned PinsW  = 34;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 4;

  // Number of job slots between the front and the back.
  localparam int unsigned QueueDepth = 2;

  localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdW-1:0] CMD_START  = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP   = 2'd2;

  localparam logic [ByteW-1:0] ACK_BYTE    = 8'h73;
  localparam logic [ByteW-1:0] FRAME_OPEN  = 8'h01;
  localparam logic [ByteW-1:0] FRAME_CLOSE = 8'h02;

  localparam logic [IdxW-1:0] FRAME_LAST_IDX = 4'd10;

  typedef enum logic {
    JOB_ACK,
    JOB_FRAME
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [CntW-1:0]    cnt;
    logic [PinsW-1:0]   snap;
  } job_t;

  // Byte at position idx of a frame. Counter and snapshot bytes interleave,
  // both big-endian, the snapshot's last two bytes together; the snapshot is taken as 40 bits wide.
  function automatic logic [ByteW-1:0] frame_byte(input job_t job, input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    b = FRAME_CLOSE;
    case (idx)
      4'd0:    b = FRAME_OPEN;
      4'd1:    b = job.cnt[31:24];
      4'd2:    b = {6'd0, job.snap[33:32]};
      4'd3:    b = job.cnt[23:16];
      4'd4:    b = job.snap[31:24];
      4'd5:    b = job.cnt[15:8];
      4'd6:    b = job.snap[23:16];
      4'd7:    b = job.cnt[7:0];
      4'd8:    b = job.snap[15:8];
      4'd9:    b = job.snap[7:0];
      default: b = FRAME_CLOSE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/cosfl_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cosfl_in_if;
  logic                          valid;
  logic                          ready;
  logic [cosfl_pkg::CmdW-1:0]    cmd;
  logic [cosfl_pkg::PinsW-1:0]   pins;

  modport source (output valid, output cmd, output pins, input ready);
  modport sink   (input valid, input cmd, input pins, output ready);
endinterface

interface cosfl_out_if;
  logic                          valid;
  logic                          ready;
  logic [cosfl_pkg::ByteW-1:0]   out_byte;
  logic                          last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[hdl/cosfl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cosfl_front #(
  parameter int unsigned NUM_LINES = 34
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [cosfl_pkg::CmdW-1:0]    cmd_i,
  input  wire logic [cosfl_pkg::PinsW-1:0]   pins_i,
  output logic                               ready_o,
  input  wire logic                          full_i,
  output logic                               push_o,
  output cosfl_pkg::job_t                    job_o
);

  function automatic logic [cosfl_pkg::PinsW-1:0] line_mask();
    logic [cosfl_pkg::PinsW-1:0] m;
    for (int i = 0; i < int'(cosfl_pkg::PinsW); i++) begin
      m[i] = (i < int'(NUM_LINES));
    end
    return m;
  endfunction

  localparam logic [cosfl_pkg::PinsW-1:0] LineMask = line_mask();

  logic                             running_q, running_d;
  logic [cosfl_pkg::PinsW-1:0]      prev_q, prev_d;
  logic [cosfl_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [cosfl_pkg::PinsW-1:0]      snap;
  logic                             accept;

  // Every word is taken as long as the queue has room, whether or not it
  // turns into a job.
  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign snap    = pins_i & LineMask;

  always_comb begin
    running_d = running_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    push_o    = 1'b0;
    job_o     = '{kind: cosfl_pkg::JOB_ACK, cnt: cnt_q, snap: snap};
    if (accept) begin
      if (cmd_i == cosfl_pkg::CMD_STOP) begin
        running_d = 1'b0;
        cnt_d     = '0;
      end else if (!running_q) begin
        if (cmd_i == cosfl_pkg::CMD_START) begin
          push_o    = 1'b1;
          prev_d    = snap;
          running_d = 1'b1;
        end
      end else if (cmd_i == cosfl_pkg::CMD_SAMPLE || cmd_i == cosfl_pkg::CMD_START) begin
        if (snap != prev_q) begin
          push_o     = 1'b1;
          job_o.kind = cosfl_pkg::JOB_FRAME;
          prev_d     = snap;
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      prev_q    <= prev_d;
      cnt_q     <= cnt_d;
    end
  end

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == cosfl_pkg::CMD_STOP) |=> (cnt_q == '0 && !running_q))
    else $error("stop did not clear counter and run state");

  a_idle_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !running_q) |-> (job_o.kind == cosfl_pkg::JOB_ACK))
    else $error("frame queued while stopped");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

[hdl/cosfl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module cosfl_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  cosfl_pkg::job_t        job_i,
  output logic                   full_o,
  output logic                   avail_o,
  input  wire logic              pop_i,
  output cosfl_pkg::job_t        job_o
);

  localparam int unsigned Depth = cosfl_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cosfl_pkg::job_t        mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign avail_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o)
    else $error("pop from an empty queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

[hdl/cosfl_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cosfl_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         avail_i,
  input  cosfl_pkg::job_t                   job_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cosfl_pkg::ByteW-1:0]       out_byte_o,
  output logic                              out_last_o
);

  cosfl_pkg::job_t                 job_q, job_d, cur;
  logic                            busy_q, busy_d;
  logic [cosfl_pkg::IdxW-1:0]      idx_q, idx_d;
  logic                            out_valid_q, out_valid_d;
  logic [cosfl_pkg::ByteW-1:0]     out_byte_q, out_byte_d;
  logic                            out_last_q, out_last_d;
  logic                            load, have, emit, emit_last;

  // The output register loads whenever it is empty or being drained, so a
  // new byte follows every cycle while a job is at hand. A job is popped
  // straight from the queue head as its first byte loads, right after the previous job's last byte.
  assign load      = !out_valid_q || out_ready_i;
  assign have      = busy_q || avail_i;
  assign cur       = busy_q ? job_q : job_i;
  assign emit      = load && have;
  assign emit_last = (cur.kind == cosfl_pkg::JOB_ACK) || (idx_q == cosfl_pkg::FRAME_LAST_IDX);
  assign pop_o     = emit && !busy_q;

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_byte_d = (cur.kind == cosfl_pkg::JOB_ACK) ? cosfl_pkg::ACK_BYTE
                                                    : cosfl_pkg::frame_byte(cur, idx_q);
      out_last_d = emit_last;
      job_d      = cur;
      if (emit_last) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        busy_d = 1'b1;
        idx_d  = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  a_busy_is_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.kind == cosfl_pkg::JOB_FRAME && idx_q != '0))
    else $error("serializer busy outside a frame");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cosfl_pkg::FRAME_LAST_IDX)
    else $error("byte index past end of frame");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (!busy_q && idx_q == '0 && out_last_q))
    else $error("job did not end after its final byte");

endmodule

`default_nettype wire

[hdl/change_of_state_frame_logger.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                Handshake
// in_i     in   cmd[1:0], pins[33:0]   valid/ready, taken when both high
// out_o    out  out_byte[7:0], last    valid/ready, taken when both high
//
// Input words are taken one per cycle while the two-entry job queue has room.
// A start acknowledge is one output byte, a changed sample an eleven-byte frame; the
// one-byte-per-cycle serializer in the back end sets the sustained rate.
// Unchanged samples, stops and ignored words produce no output bytes.
// Reset is asynchronous and active low and clears run state, counter,
// previous snapshot, queue and serializer. A stall on out_o fills the queue
// and then holds in_i.ready low.

module change_of_state_frame_logger #(
  parameter int unsigned NUM_LINES = 34
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cosfl_in_if.sink       in_i,
  cosfl_out_if.source    out_o
);

  logic             full, avail, push, pop;
  cosfl_pkg::job_t  push_job, head_job;

  cosfl_front #(
    .NUM_LINES (NUM_LINES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .cmd_i   (in_i.cmd),
    .pins_i  (in_i.pins),
    .ready_o (in_i.ready),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  cosfl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .avail_o (avail),
    .pop_i   (pop),
    .job_o   (head_job)
  );

  cosfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last)
  );

endmodule

`default_nettype wire

[test/change_of_state_frame_logger_tb.sv]
`timescale 1ns / 1ps

module change_of_state_frame_logger_tb;

  localparam int unsigned NUM_LINES   = 34;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_WORDS = 20;
  localparam int unsigned PRINT_CAP   = 100;

  localparam logic [cosfl_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [cosfl_pkg::CmdW-1:0]  cmd;
    logic [cosfl_pkg::PinsW-1:0] pins;
  } sample_word_t;

  typedef struct packed {
    logic [cosfl_pkg::ByteW-1:0] data;
    logic                        last;
  } log_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cosfl_in_if  in_if ();
  cosfl_out_if out_if ();

  change_of_state_frame_logger #(
    .NUM_LINES (NUM_LINES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  sample_word_t pending_words[$];
  log_byte_t    expected_bytes[$];
  idle_mode_e   idle_mode   = IDLE_NONE;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           word_taken  = 1'b0;

  // Predicted state of the logger.
  logic [cosfl_pkg::PinsW-1:0] last_snap    = '0;
  logic [cosfl_pkg::CntW-1:0]  sample_count = '0;
  bit                          acquiring    = 1'b0;

  // Generator view of the run state, used to count words that do something.
  bit                          gen_running = 1'b0;
  logic [cosfl_pkg::PinsW-1:0] gen_pins    = '0;
  int unsigned                 gen_counted = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] log mismatch: %s", $time, what);
    end
  endtask

  task automatic push_log_byte(input logic [cosfl_pkg::ByteW-1:0] data, input logic last);
    log_byte_t b;
    b.data = data;
    b.last = last;
    expected_bytes.push_back(b);
  endtask

  task automatic predict_log(input sample_word_t w);
    logic [63:0]                 line_mask;
    logic [cosfl_pkg::PinsW-1:0] snap;
    logic [39:0]                 wide;
    line_mask = (64'd1 << NUM_LINES) - 64'd1;
    snap = w.pins & line_mask[cosfl_pkg::PinsW-1:0];
    wide = {{(40 - cosfl_pkg::PinsW){1'b0}}, snap};
    if (w.cmd == cosfl_pkg::CMD_STOP) begin
      acquiring    = 1'b0;
      sample_count = '0;
    end else if (!acquiring) begin
      if (w.cmd == cosfl_pkg::CMD_START) begin
        push_log_byte(cosfl_pkg::ACK_BYTE, 1'b1);
        last_snap = snap;
        acquiring = 1'b1;
      end
    end else if (w.cmd == cosfl_pkg::CMD_SAMPLE || w.cmd == cosfl_pkg::CMD_START) begin
      if (snap != last_snap) begin
        // Counter and snapshot bytes alternate, most significant first, the last two snapshot bytes together.
        push_log_byte(cosfl_pkg::FRAME_OPEN, 1'b0);
        push_log_byte(sample_count[31:24], 1'b0);
        push_log_byte(wide[39:32], 1'b0);
        push_log_byte(sample_count[23:16], 1'b0);
        push_log_byte(wide[31:24], 1'b0);
        push_log_byte(sample_count[15:8], 1'b0);
        push_log_byte(wide[23:16], 1'b0);
        push_log_byte(sample_count[7:0], 1'b0);
        push_log_byte(wide[15:8], 1'b0);
        push_log_byte(wide[7:0], 1'b0);
        push_log_byte(cosfl_pkg::FRAME_CLOSE, 1'b1);
        last_snap = snap;
      end
      sample_count = sample_count + 1'b1;
    end
  endtask

  function automatic logic [cosfl_pkg::PinsW-1:0] random_pins();
    logic [cosfl_pkg::PinsW-1:0] p;
    p[31:0]                  = $urandom;
    p[cosfl_pkg::PinsW-1:32] = (cosfl_pkg::PinsW - 32)'($urandom_range(3, 0));
    return p;
  endfunction

  task automatic queue_word(input logic [cosfl_pkg::CmdW-1:0] cmd,
                            input logic [cosfl_pkg::PinsW-1:0] pins);
    sample_word_t w;
    w.cmd  = cmd;
    w.pins = pins;
    pending_words.push_back(w);
    if (cmd == cosfl_pkg::CMD_STOP || cmd == cosfl_pkg::CMD_START ||
        (cmd == cosfl_pkg::CMD_SAMPLE && gen_running)) begin
      gen_counted++;
    end
    if (cmd == cosfl_pkg::CMD_START) begin
      gen_running = 1'b1;
    end else if (cmd == cosfl_pkg::CMD_STOP) begin
      gen_running = 1'b0;
    end
    gen_pins = pins;
  endtask

  // Mostly complete acquisitions: start, a run of samples that mostly change,
  // then stop. The rest is loose words with any command.
  task automatic queue_random_words(input int unsigned target);
    int unsigned                 stop_at;
    int unsigned                 len;
    int unsigned                 r;
    logic [cosfl_pkg::PinsW-1:0] p;
    logic [cosfl_pkg::CmdW-1:0]  c;
    stop_at = gen_counted + target;
    while (gen_counted < stop_at) begin
      if ($urandom_range(99, 0) < 85) begin
        queue_word(cosfl_pkg::CMD_START, random_pins());
        len = $urandom_range(10, 2);
        repeat (len) begin
          r = $urandom_range(99, 0);
          if (r < 50) begin
            p = gen_pins ^ (34'd1 << $urandom_range(cosfl_pkg::PinsW - 1, 0));
          end else if (r < 75) begin
            p = random_pins();
          end else begin
            p = gen_pins;
          end
          r = $urandom_range(99, 0);
          if (r < 6) begin
            queue_word(CMD_UNUSED, random_pins());
          end else if (r < 12) begin
            queue_word(cosfl_pkg::CMD_START, p);
          end else begin
            queue_word(cosfl_pkg::CMD_SAMPLE, p);
          end
        end
        if ($urandom_range(99, 0) < 85) begin
          queue_word(cosfl_pkg::CMD_STOP, random_pins());
        end
      end else begin
        c = cosfl_pkg::CmdW'($urandom_range(3, 0));
        queue_word(c, random_pins());
      end
    end
  endtask

  // Accepted words go to the predictor; accepted log bytes are checked.
  always @(posedge clk) begin
    log_byte_t want;
    sample_word_t w;
    cycle_count++;
    word_taken = in_if.valid && in_if.ready;
    if (word_taken) begin
      w.cmd  = in_if.cmd;
      w.pins = in_if.pins;
      predict_log(w);
    end
    if (out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_if.out_byte, out_if.last));
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.out_byte !== want.data) begin
          report_mismatch($sformatf("byte %02h, expected %02h", out_if.out_byte, want.data));
        end
        if (out_if.last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                    out_if.last, want.last, want.data));
        end
      end
    end
  end

  // A word is held until it is taken; a new one may follow with no gap.
  always @(negedge clk) begin
    sample_word_t w;
    int unsigned  gap_pct;
    int unsigned  stall_pct;
    gap_pct   = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if (rst_n) begin
      if (!in_if.valid || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          w = pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_if.cmd   <= w.cmd;
          in_if.pins  <= w.pins;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.cmd    = cosfl_pkg::CMD_SAMPLE;
    in_if.pins   = '0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    queue_word(cosfl_pkg::CMD_START, '0);
    queue_word(cosfl_pkg::CMD_SAMPLE, '1);
    // Same snapshot again: no frame, but the counter still advances.
    queue_word(cosfl_pkg::CMD_SAMPLE, '1);
    queue_word(cosfl_pkg::CMD_SAMPLE, '0);
    queue_word(cosfl_pkg::CMD_SAMPLE, 34'h2_AAAA_AAAA);
    queue_word(cosfl_pkg::CMD_SAMPLE, 34'h1_5555_5555);
    // A start while running counts as a plain sample.
    queue_word(cosfl_pkg::CMD_START, 34'h2_0000_0000);
    queue_word(CMD_UNUSED, '1);
    queue_word(cosfl_pkg::CMD_SAMPLE, 34'h0_0000_0001);
    queue_word(cosfl_pkg::CMD_STOP, '1);
    // Stopped: samples and the unused code are dropped, a second stop is harmless.
    queue_word(cosfl_pkg::CMD_SAMPLE, '1);
    queue_word(CMD_UNUSED, 34'h1_2345_6789);
    queue_word(cosfl_pkg::CMD_STOP, '0);
    queue_word(cosfl_pkg::CMD_START, '1);
    queue_word(cosfl_pkg::CMD_SAMPLE, '1);
    queue_word(cosfl_pkg::CMD_SAMPLE, 34'h2_0000_0000);
    queue_word(cosfl_pkg::CMD_SAMPLE, 34'h1_0000_0000);
    queue_word(cosfl_pkg::CMD_STOP, '0);

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = idle_mode_e'(m);
      queue_random_words(PHASE_WORDS);
      while (pending_words.size() != 0 || in_if.valid) begin
        @(posedge clk);
      end
    end

    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/cosfl_pkg.sv
hdl/cosfl_if.sv
hdl/cosfl_front.sv
hdl/cosfl_queue.sv
hdl/cosfl_back.sv
hdl/change_of_state_frame_logger.sv
test/change_of_state_frame_logger_tb.sv
